### hdl/dns_response_min_ttl_scanner_assert.svh
// assertion macros used by the scanner top level
`ifndef DNS_RESPONSE_MIN_TTL_SCANNER_ASSERT_SVH
`define DNS_RESPONSE_MIN_TTL_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define DMTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DMTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DMTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define DMTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/dmts_pkg.sv
// shared types and constants of the dns minimum ttl scanner
`timescale 1ns / 1ps

package dmts_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TTL_OUT_W = 16;

  localparam logic [TTL_OUT_W-1:0] TTL_CAP_RESET = 16'd300;

  // one message byte beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [TTL_OUT_W-1:0] ttl_seconds;
    logic                 parse_error;
  } result_t;

endpackage

### hdl/dmts_in_reg.sv
// input register stage holding one message byte beat
`timescale 1ns / 1ps

module dmts_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dmts_pkg::beat_t beat_in,
  input  logic           advance,
  output logic           held_valid,
  output dmts_pkg::beat_t held_beat
);

  // free when empty or when the held beat moves on this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= beat_in;
    end
  end

endmodule

### hdl/dmts_parser.sv
// parser state and per-byte step logic of the scanner
`timescale 1ns / 1ps

module dmts_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [dmts_pkg::TTL_OUT_W-1:0]     cfg_write_data,
  input  logic                               fire,
  input  dmts_pkg::beat_t                    beat,
  output dmts_pkg::result_t                  result
);

  typedef enum logic [13:0] {
    PH_HDR  = 14'b00000000000001,
    PH_QLEN = 14'b00000000000010,
    PH_QLAB = 14'b00000000000100,
    PH_QPTR = 14'b00000000001000,
    PH_QFIX = 14'b00000000010000,
    PH_ALEN = 14'b00000000100000,
    PH_ALAB = 14'b00000001000000,
    PH_APTR = 14'b00000010000000,
    PH_AFIX = 14'b00000100000000,
    PH_TTL  = 14'b00001000000000,
    PH_RDL  = 14'b00010000000000,
    PH_RDAT = 14'b00100000000000,
    PH_DONE = 14'b01000000000000,
    PH_ERR  = 14'b10000000000000
  } phase_t;

  localparam logic [3:0] HDR_LEN    = 4'd12;
  localparam logic [3:0] QDCOUNT_HI = 4'd4;
  localparam logic [3:0] QDCOUNT_LO = 4'd5;
  localparam logic [3:0] ANCOUNT_HI = 4'd6;
  localparam logic [3:0] ANCOUNT_LO = 4'd7;
  localparam logic [3:0] FIX_LEN    = 4'd4;
  localparam logic [3:0] TTL_LEN    = 4'd4;
  localparam logic [3:0] RDL_LEN    = 4'd2;
  localparam logic [1:0] PTR_MARK   = 2'b11;

  phase_t      phase, phase_next;
  logic [3:0]  byte_index, byte_index_next, byte_inc;
  logic [15:0] question_total, question_total_next;
  logic [15:0] answers_left, answers_left_next;
  logic [15:0] skip_left, skip_left_next;
  logic [31:0] ttl_shift, ttl_shift_next;
  logic [15:0] rdlength_shift, rdlength_shift_next;
  logic [31:0] least_ttl, least_ttl_next;
  logic [15:0] ttl_cap;
  logic [7:0]  b;
  logic        bad;

  assign b = beat.data_byte;
  assign byte_inc = byte_index + 4'd1;

  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    question_total_next = question_total;
    answers_left_next   = answers_left;
    skip_left_next      = skip_left;
    ttl_shift_next      = ttl_shift;
    rdlength_shift_next = rdlength_shift;
    least_ttl_next      = least_ttl;

    unique case (phase) inside
      PH_HDR: begin
        if (byte_index == QDCOUNT_HI) begin
          question_total_next = {b, 8'h00};
        end else if (byte_index == QDCOUNT_LO) begin
          question_total_next = {question_total[15:8], b};
        end else if (byte_index == ANCOUNT_HI) begin
          answers_left_next = {b, 8'h00};
        end else if (byte_index == ANCOUNT_LO) begin
          answers_left_next = {answers_left[15:8], b};
        end
        byte_index_next = byte_inc;
        if (byte_inc == HDR_LEN) begin
          byte_index_next = '0;
          if (question_total_next != 16'd1 || beat.last_byte) begin
            phase_next = PH_ERR;
          end else begin
            phase_next = PH_QLEN;
          end
        end
      end
      PH_QLEN, PH_ALEN: begin
        // label length byte, pointer ends the name, zero ends it too
        if (b[7:6] == PTR_MARK) begin
          phase_next = (phase == PH_QLEN) ? PH_QPTR : PH_APTR;
        end else if (b[5:0] == 6'd0) begin
          byte_index_next = '0;
          phase_next = (phase == PH_QLEN) ? PH_QFIX : PH_AFIX;
        end else begin
          skip_left_next = {10'd0, b[5:0]};
          phase_next = (phase == PH_QLEN) ? PH_QLAB : PH_ALAB;
        end
      end
      PH_QLAB, PH_ALAB: begin
        skip_left_next = skip_left - 16'd1;
        if (skip_left_next == 16'd0) begin
          phase_next = (phase == PH_QLAB) ? PH_QLEN : PH_ALEN;
        end
      end
      PH_QPTR: begin
        byte_index_next = '0;
        phase_next = PH_QFIX;
      end
      PH_APTR: begin
        byte_index_next = '0;
        phase_next = PH_AFIX;
      end
      PH_QFIX: begin
        byte_index_next = byte_inc;
        if (byte_inc == FIX_LEN) begin
          byte_index_next = '0;
          phase_next = (answers_left != 16'd0) ? PH_ALEN : PH_DONE;
        end
      end
      PH_AFIX: begin
        byte_index_next = byte_inc;
        if (byte_inc == FIX_LEN) begin
          byte_index_next = '0;
          phase_next = PH_TTL;
        end
      end
      PH_TTL: begin
        ttl_shift_next = {ttl_shift[23:0], b};
        byte_index_next = byte_inc;
        if (byte_inc == TTL_LEN) begin
          byte_index_next = '0;
          phase_next = PH_RDL;
        end
      end
      PH_RDL: begin
        rdlength_shift_next = {rdlength_shift[7:0], b};
        byte_index_next = byte_inc;
        if (byte_inc == RDL_LEN) begin
          byte_index_next = '0;
          // rdlength taken, the record's ttl now counts
          if (ttl_shift < least_ttl) begin
            least_ttl_next = ttl_shift;
          end
          answers_left_next = answers_left - 16'd1;
          if (rdlength_shift_next == 16'd0) begin
            phase_next = (answers_left_next != 16'd0) ? PH_ALEN : PH_DONE;
          end else begin
            skip_left_next = rdlength_shift_next;
            phase_next = PH_RDAT;
          end
        end
      end
      PH_RDAT: begin
        skip_left_next = skip_left - 16'd1;
        if (skip_left_next == 16'd0) begin
          byte_index_next = '0;
          phase_next = (answers_left != 16'd0) ? PH_ALEN : PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // verdict on the final byte, taken from the post-step state
  always_comb begin
    unique case (phase_next) inside
      PH_QLEN, PH_QLAB, PH_QPTR, PH_QFIX, PH_RDAT: bad = (answers_left_next != 16'd0);
      PH_DONE: bad = 1'b0;
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    result.parse_error = bad;
    if (bad || least_ttl_next == '1) begin
      result.ttl_seconds = '0;
    end else if (least_ttl_next < {16'd0, ttl_cap}) begin
      result.ttl_seconds = least_ttl_next[15:0];
    end else begin
      result.ttl_seconds = ttl_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_cap        <= dmts_pkg::TTL_CAP_RESET;
      phase          <= PH_HDR;
      byte_index     <= '0;
      question_total <= '0;
      answers_left   <= '0;
      skip_left      <= '0;
      least_ttl      <= '1;
    end else begin
      if (cfg_write_enable) begin
        ttl_cap <= cfg_write_data;
      end
      if (fire) begin
        if (beat.last_byte) begin
          phase          <= PH_HDR;
          byte_index     <= '0;
          question_total <= '0;
          answers_left   <= '0;
          skip_left      <= '0;
          least_ttl      <= '1;
        end else begin
          phase          <= phase_next;
          byte_index     <= byte_index_next;
          question_total <= question_total_next;
          answers_left   <= answers_left_next;
          skip_left      <= skip_left_next;
          least_ttl      <= least_ttl_next;
        end
      end
    end
  end

  // field shift registers, always fully loaded before use
  always_ff @(posedge clk) begin
    if (fire) begin
      ttl_shift      <= ttl_shift_next;
      rdlength_shift <= rdlength_shift_next;
    end
  end

endmodule

### hdl/dmts_out_reg.sv
// result register holding one result beat until taken
`timescale 1ns / 1ps

module dmts_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  dmts_pkg::result_t              result_in,
  output logic                           free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dmts_pkg::TTL_OUT_W-1:0] ttl_seconds,
  output logic                           parse_error
);

  dmts_pkg::result_t held;

  assign free        = !out_valid || out_ready;
  assign ttl_seconds = held.ttl_seconds;
  assign parse_error = held.parse_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result_in;
    end
  end

endmodule

### hdl/dns_response_min_ttl_scanner.sv
// top level of the dns response minimum ttl scanner
`timescale 1ns / 1ps
`include "dns_response_min_ttl_scanner_assert.svh"

// takes a dns response one byte per beat (last_byte on the final one), walks
// header, the single question and all answer records, and gives one result
// beat per message: the least answer ttl limited to ttl_cap (zero with no
// answers), or zero with parse_error set for a message ending in the header or
// before its last answer's rdlength, or with a question count other than one.
// throughput is one byte per clock outside stalls: a byte sits in the input
// register, then the parser step (one short pass of compare and select logic on
// the parser state) commits it. a final byte loads the result register at that
// commit, and the result beat shows in the cycle after it. the only stall is a
// final byte meeting a result that is still waiting to be taken; other bytes keep
// flowing. ttl_cap resets to 300 and is written through the config port
// between messages by the user; the block itself does not enforce it.

module dns_response_min_ttl_scanner (
  input  logic                           clk,
  input  logic                           rst,
  // config register
  input  logic                           cfg_write_enable,
  input  logic [dmts_pkg::TTL_OUT_W-1:0] cfg_write_data,
  // message byte beats
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dmts_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           last_byte,
  // result beats
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dmts_pkg::TTL_OUT_W-1:0] ttl_seconds,
  output logic                           parse_error
);

  dmts_pkg::beat_t   beat_in;
  dmts_pkg::beat_t   held_beat;
  dmts_pkg::result_t step_result;
  logic              held_valid;
  logic              out_free;
  logic              advance;
  logic              load_result;

  assign beat_in.data_byte = data_byte;
  assign beat_in.last_byte = last_byte;

  // a non-final byte always moves; a final one needs room for its result
  assign advance     = held_valid && (!held_beat.last_byte || out_free);
  assign load_result = advance && held_beat.last_byte;

  dmts_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .beat_in    (beat_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  // header, name walking, ttl and rdlength capture, minimum tracking
  dmts_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .fire             (advance),
    .beat             (held_beat),
    .result           (step_result)
  );

  dmts_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (load_result),
    .result_in   (step_result),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ttl_seconds (ttl_seconds),
    .parse_error (parse_error)
  );

  // a committed final byte always leaves a result beat on the output
  `DMTS_ASSERT_NEXT(a_last_gives_result, clk, rst, load_result, out_valid,
                    "final byte lost its result")

  // back pressure only from a final byte waiting behind an untaken result
  `DMTS_ASSERT_IMPLY(a_stall_cause, clk, rst, !in_ready,
                     held_valid && held_beat.last_byte && out_valid && !out_ready,
                     "input stalled without cause")

  // an errored message never reports a ttl
  `DMTS_ASSERT_IMPLY(a_error_zero_ttl, clk, rst, out_valid && parse_error,
                     ttl_seconds == '0, "error result carries a ttl")

endmodule
